FILE: sv/text_mode_teletype_console_macros.svh
// Assertion helpers shared by the console RTL.
`ifndef TEXT_MODE_TELETYPE_CONSOLE_MACROS_SVH
`define TEXT_MODE_TELETYPE_CONSOLE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TMTC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TMTC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/tmtc_pkg.sv
`default_nettype none

package tmtc_pkg;

    localparam int ROWS    = 25;
    localparam int COLS    = 80;
    localparam int CELLS   = ROWS * COLS;
    localparam int ROW_W   = $clog2(ROWS);
    localparam int COL_W   = $clog2(COLS);
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int CELL_W  = 16;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int REG_IDX_W = PADDR_W - 2;

    localparam logic [7:0] RESET_ATTR      = 8'h0F;
    localparam logic [7:0] RESET_TEXT_ATTR = 8'd15;
    localparam logic [7:0] NEWLINE_CODE    = 8'd10;
    localparam logic [7:0] BLANK_CODE      = 8'd32;

    localparam logic [REG_IDX_W-1:0] REG_TEXT_ATTR = '0;

    localparam logic [2:0] OP_PUT          = 3'd0;
    localparam logic [2:0] OP_PUT_AT       = 3'd1;
    localparam logic [2:0] OP_BACKSPACE    = 3'd2;
    localparam logic [2:0] OP_CLEAR_SCREEN = 3'd3;
    localparam logic [2:0] OP_CLEAR_LINE   = 3'd4;
    localparam logic [2:0] OP_SET_CURSOR   = 3'd5;
    localparam logic [2:0] OP_READ_CHAR    = 3'd6;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [ROW_W-1:0]  row_t;
    typedef logic [COL_W-1:0]  col_t;
    typedef logic [CELL_W-1:0] cell_t;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] char_code;
        logic [7:0] target_row;
        logic [7:0] target_col;
    } in_t;

    typedef struct packed {
        logic [7:0] char_read;
        logic [7:0] cursor_row_out;
        logic [7:0] cursor_col_out;
    } out_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_RD_WAIT,
        ST_COPY,
        ST_COPY_LAST,
        ST_FILL,
        ST_RESP
    } state_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_CURSOR,
        WR_TARGET,
        WR_BACK,
        WR_FILL,
        WR_INIT
    } wr_sel_t;

    typedef enum logic [2:0] {
        CUR_HOLD,
        CUR_INC_COL,
        CUR_NEXT_ROW,
        CUR_BACK,
        CUR_HOME,
        CUR_SET
    } cur_cmd_t;

    typedef enum logic [1:0] {
        WALK_ALL,
        WALK_ROW,
        WALK_COPY,
        WALK_LAST
    } walk_sel_t;

    typedef enum logic [1:0] {
        CHR_HOLD,
        CHR_CLEAR,
        CHR_BLANK,
        CHR_MEM
    } chr_sel_t;

    typedef struct packed {
        logic      capture;
        wr_sel_t   wr_sel;
        cur_cmd_t  cur_cmd;
        logic      walk_start;
        walk_sel_t walk_sel;
        logic      walk_step;
        logic      copy_step;
        chr_sel_t  chr_sel;
        logic      resp_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] opcode;
        logic       is_newline;
        logic       row_ok;
        logic       col_ok;
        logic       at_origin;
        logic       last_col;
        logic       last_row;
        logic       walk_done;
        logic       out_free;
    } dp_status_t;

endpackage

`default_nettype wire

FILE: sv/tmtc_ram.sv
`default_nettype none

module tmtc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: sv/tmtc_dp.sv
`default_nettype none

module tmtc_dp (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire tmtc_pkg::in_t        s_data,
    input  wire logic [7:0]           attr,
    input  wire tmtc_pkg::dp_cmd_t    cmd,
    output tmtc_pkg::dp_status_t      status,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output tmtc_pkg::out_t            m_data
);

    tmtc_pkg::in_t   in_reg;
    tmtc_pkg::row_t  cur_row_reg, cur_row_next;
    tmtc_pkg::col_t  cur_col_reg, cur_col_next;
    tmtc_pkg::addr_t walk_reg, walk_next;
    tmtc_pkg::addr_t end_reg, end_next;
    logic            pend_reg;
    tmtc_pkg::addr_t pend_addr_reg;
    logic [7:0]      chr_reg, chr_next;
    tmtc_pkg::out_t  out_reg;
    logic            out_valid_reg;

    logic            row_ok, col_ok;
    tmtc_pkg::row_t  tgt_row;
    tmtc_pkg::col_t  tgt_col;
    tmtc_pkg::addr_t row_base, tgt_addr, cur_addr;
    logic            last_row, last_col;

    logic            ram_we;
    tmtc_pkg::addr_t ram_waddr, ram_raddr;
    tmtc_pkg::cell_t ram_wdata, ram_rdata;

    assign row_ok   = in_reg.target_row < 8'(tmtc_pkg::ROWS);
    assign col_ok   = in_reg.target_col < 8'(tmtc_pkg::COLS);
    assign tgt_row  = in_reg.target_row[tmtc_pkg::ROW_W-1:0];
    assign tgt_col  = in_reg.target_col[tmtc_pkg::COL_W-1:0];
    assign row_base = tmtc_pkg::addr_t'(tgt_row) * tmtc_pkg::addr_t'(tmtc_pkg::COLS);
    assign tgt_addr = row_base + tmtc_pkg::addr_t'(tgt_col);
    assign cur_addr = tmtc_pkg::addr_t'(cur_row_reg) * tmtc_pkg::addr_t'(tmtc_pkg::COLS)
                    + tmtc_pkg::addr_t'(cur_col_reg);
    assign last_row = cur_row_reg == tmtc_pkg::row_t'(tmtc_pkg::ROWS - 1);
    assign last_col = cur_col_reg == tmtc_pkg::col_t'(tmtc_pkg::COLS - 1);

    always_comb begin
        status.opcode     = in_reg.opcode;
        status.is_newline = in_reg.char_code == tmtc_pkg::NEWLINE_CODE;
        status.row_ok     = row_ok;
        status.col_ok     = col_ok;
        status.at_origin  = (cur_row_reg == '0) && (cur_col_reg == '0);
        status.last_col   = last_col;
        status.last_row   = last_row;
        status.walk_done  = walk_reg == end_reg;
        status.out_free   = !out_valid_reg || m_ready;
    end

    // A pending scroll copy owns the write port whenever no other write is commanded.
    always_comb begin
        ram_we    = 1'b1;
        ram_waddr = cur_addr;
        ram_wdata = {attr, in_reg.char_code};
        unique case (cmd.wr_sel)
            tmtc_pkg::WR_NONE: begin
                ram_we    = pend_reg;
                ram_waddr = pend_addr_reg;
                ram_wdata = ram_rdata;
            end
            tmtc_pkg::WR_CURSOR: begin
                ram_waddr = cur_addr;
                ram_wdata = {attr, in_reg.char_code};
            end
            tmtc_pkg::WR_TARGET: begin
                ram_waddr = tgt_addr;
                ram_wdata = {attr, in_reg.char_code};
            end
            tmtc_pkg::WR_BACK: begin
                // The cell left of the cursor is one address lower, across rows too.
                ram_waddr = cur_addr - tmtc_pkg::addr_t'(1);
                ram_wdata = {attr, tmtc_pkg::BLANK_CODE};
            end
            tmtc_pkg::WR_FILL: begin
                ram_waddr = walk_reg;
                ram_wdata = {attr, tmtc_pkg::BLANK_CODE};
            end
            tmtc_pkg::WR_INIT: begin
                ram_waddr = walk_reg;
                ram_wdata = {tmtc_pkg::RESET_ATTR, tmtc_pkg::BLANK_CODE};
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign ram_raddr = cmd.copy_step ? walk_reg : tgt_addr;

    tmtc_ram #(
        .WIDTH (tmtc_pkg::CELL_W),
        .DEPTH (tmtc_pkg::CELLS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        unique case (cmd.cur_cmd)
            tmtc_pkg::CUR_HOLD: begin
            end
            tmtc_pkg::CUR_INC_COL: begin
                cur_col_next = cur_col_reg + tmtc_pkg::col_t'(1);
            end
            tmtc_pkg::CUR_NEXT_ROW: begin
                cur_col_next = '0;
                if (!last_row) begin
                    cur_row_next = cur_row_reg + tmtc_pkg::row_t'(1);
                end
            end
            tmtc_pkg::CUR_BACK: begin
                if (cur_col_reg == '0) begin
                    cur_row_next = cur_row_reg - tmtc_pkg::row_t'(1);
                    cur_col_next = tmtc_pkg::col_t'(tmtc_pkg::COLS - 1);
                end else begin
                    cur_col_next = cur_col_reg - tmtc_pkg::col_t'(1);
                end
            end
            tmtc_pkg::CUR_HOME: begin
                cur_row_next = '0;
                cur_col_next = '0;
            end
            tmtc_pkg::CUR_SET: begin
                if (row_ok) begin
                    cur_row_next = tgt_row;
                end
                if (col_ok) begin
                    cur_col_next = tgt_col;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        walk_next = walk_reg;
        end_next  = end_reg;
        if (cmd.walk_start) begin
            unique case (cmd.walk_sel)
                tmtc_pkg::WALK_ALL: begin
                    walk_next = '0;
                    end_next  = tmtc_pkg::addr_t'(tmtc_pkg::CELLS - 1);
                end
                tmtc_pkg::WALK_ROW: begin
                    walk_next = row_base;
                    end_next  = row_base + tmtc_pkg::addr_t'(tmtc_pkg::COLS - 1);
                end
                tmtc_pkg::WALK_COPY: begin
                    walk_next = tmtc_pkg::addr_t'(tmtc_pkg::COLS);
                    end_next  = tmtc_pkg::addr_t'(tmtc_pkg::CELLS - 1);
                end
                tmtc_pkg::WALK_LAST: begin
                    walk_next = tmtc_pkg::addr_t'((tmtc_pkg::ROWS - 1) * tmtc_pkg::COLS);
                    end_next  = tmtc_pkg::addr_t'(tmtc_pkg::CELLS - 1);
                end
                default: begin
                end
            endcase
        end else if (cmd.walk_step || cmd.copy_step) begin
            walk_next = walk_reg + tmtc_pkg::addr_t'(1);
        end
    end

    always_comb begin
        chr_next = chr_reg;
        unique case (cmd.chr_sel)
            tmtc_pkg::CHR_HOLD:  chr_next = chr_reg;
            tmtc_pkg::CHR_CLEAR: chr_next = 8'd0;
            tmtc_pkg::CHR_BLANK: chr_next = tmtc_pkg::BLANK_CODE;
            tmtc_pkg::CHR_MEM:   chr_next = ram_rdata[7:0];
            default:             chr_next = chr_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            walk_reg      <= '0;
            end_reg       <= tmtc_pkg::addr_t'(tmtc_pkg::CELLS - 1);
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            cur_row_reg <= cur_row_next;
            cur_col_reg <= cur_col_next;
            walk_reg    <= walk_next;
            end_reg     <= end_next;
            pend_reg    <= cmd.copy_step;
            if (cmd.resp_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_reg <= s_data;
        end
        pend_addr_reg <= walk_reg - tmtc_pkg::addr_t'(tmtc_pkg::COLS);
        chr_reg       <= chr_next;
        if (cmd.resp_load) begin
            out_reg.char_read      <= chr_reg;
            out_reg.cursor_row_out <= 8'(cur_row_reg);
            out_reg.cursor_col_out <= 8'(cur_col_reg);
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

`include "text_mode_teletype_console_macros.svh"

    `TMTC_ASSERT_NOW(a_row_range, 1'b1, cur_row_reg < tmtc_pkg::row_t'(tmtc_pkg::ROWS), "cursor row out of range")
    `TMTC_ASSERT_NOW(a_col_range, 1'b1, cur_col_reg < tmtc_pkg::col_t'(tmtc_pkg::COLS), "cursor column out of range")
    `TMTC_ASSERT_NOW(a_copy_port_free, pend_reg, cmd.wr_sel == tmtc_pkg::WR_NONE, "write collides with scroll copy")
    `TMTC_ASSERT_NEXT(a_resp_valid, cmd.resp_load, out_valid_reg, "loaded response not presented")

endmodule

`default_nettype wire

FILE: sv/tmtc_ctrl.sv
`default_nettype none

module tmtc_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire tmtc_pkg::dp_status_t  status,
    output tmtc_pkg::dp_cmd_t          cmd
);

    tmtc_pkg::state_t state_reg, state_next;
    logic             scroll;
    logic             tgt_ok;

    assign scroll = (status.is_newline || status.last_col) && status.last_row;
    assign tgt_ok = status.row_ok && status.col_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tmtc_pkg::ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tmtc_pkg::ST_INIT: begin
                if (status.walk_done) begin
                    state_next = tmtc_pkg::ST_IDLE;
                end
            end
            tmtc_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = tmtc_pkg::ST_EXEC;
                end
            end
            tmtc_pkg::ST_EXEC: begin
                state_next = tmtc_pkg::ST_RESP;
                unique case (status.opcode)
                    tmtc_pkg::OP_PUT: begin
                        if (scroll) begin
                            state_next = tmtc_pkg::ST_COPY;
                        end
                    end
                    tmtc_pkg::OP_CLEAR_SCREEN: state_next = tmtc_pkg::ST_FILL;
                    tmtc_pkg::OP_CLEAR_LINE: begin
                        if (status.row_ok) begin
                            state_next = tmtc_pkg::ST_FILL;
                        end
                    end
                    tmtc_pkg::OP_READ_CHAR: begin
                        if (tgt_ok) begin
                            state_next = tmtc_pkg::ST_RD_WAIT;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            tmtc_pkg::ST_RD_WAIT: state_next = tmtc_pkg::ST_RESP;
            tmtc_pkg::ST_COPY: begin
                if (status.walk_done) begin
                    state_next = tmtc_pkg::ST_COPY_LAST;
                end
            end
            tmtc_pkg::ST_COPY_LAST: state_next = tmtc_pkg::ST_FILL;
            tmtc_pkg::ST_FILL: begin
                if (status.walk_done) begin
                    state_next = tmtc_pkg::ST_RESP;
                end
            end
            tmtc_pkg::ST_RESP: begin
                if (status.out_free) begin
                    state_next = tmtc_pkg::ST_IDLE;
                end
            end
            default: state_next = tmtc_pkg::ST_INIT;
        endcase
    end

    always_comb begin
        s_ready        = 1'b0;
        cmd.capture    = 1'b0;
        cmd.wr_sel     = tmtc_pkg::WR_NONE;
        cmd.cur_cmd    = tmtc_pkg::CUR_HOLD;
        cmd.walk_start = 1'b0;
        cmd.walk_sel   = tmtc_pkg::WALK_ALL;
        cmd.walk_step  = 1'b0;
        cmd.copy_step  = 1'b0;
        cmd.chr_sel    = tmtc_pkg::CHR_HOLD;
        cmd.resp_load  = 1'b0;
        unique case (state_reg)
            tmtc_pkg::ST_INIT: begin
                cmd.wr_sel    = tmtc_pkg::WR_INIT;
                cmd.walk_step = 1'b1;
            end
            tmtc_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
                if (s_valid) begin
                    cmd.chr_sel = tmtc_pkg::CHR_CLEAR;
                end
            end
            tmtc_pkg::ST_EXEC: begin
                unique case (status.opcode)
                    tmtc_pkg::OP_PUT: begin
                        if (status.is_newline) begin
                            cmd.cur_cmd = tmtc_pkg::CUR_NEXT_ROW;
                        end else begin
                            cmd.wr_sel  = tmtc_pkg::WR_CURSOR;
                            cmd.cur_cmd = status.last_col ? tmtc_pkg::CUR_NEXT_ROW
                                                          : tmtc_pkg::CUR_INC_COL;
                        end
                        cmd.walk_start = scroll;
                        cmd.walk_sel   = tmtc_pkg::WALK_COPY;
                    end
                    tmtc_pkg::OP_PUT_AT: begin
                        if (tgt_ok) begin
                            cmd.wr_sel = tmtc_pkg::WR_TARGET;
                        end
                    end
                    tmtc_pkg::OP_BACKSPACE: begin
                        if (!status.at_origin) begin
                            cmd.wr_sel  = tmtc_pkg::WR_BACK;
                            cmd.cur_cmd = tmtc_pkg::CUR_BACK;
                        end
                    end
                    tmtc_pkg::OP_CLEAR_SCREEN: begin
                        cmd.cur_cmd    = tmtc_pkg::CUR_HOME;
                        cmd.walk_start = 1'b1;
                        cmd.walk_sel   = tmtc_pkg::WALK_ALL;
                    end
                    tmtc_pkg::OP_CLEAR_LINE: begin
                        cmd.walk_start = status.row_ok;
                        cmd.walk_sel   = tmtc_pkg::WALK_ROW;
                    end
                    tmtc_pkg::OP_SET_CURSOR: begin
                        cmd.cur_cmd = tmtc_pkg::CUR_SET;
                    end
                    tmtc_pkg::OP_READ_CHAR: begin
                        // An in-range read already has its address on the RAM port.
                        if (!tgt_ok) begin
                            cmd.chr_sel = tmtc_pkg::CHR_BLANK;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            tmtc_pkg::ST_RD_WAIT: begin
                cmd.chr_sel = tmtc_pkg::CHR_MEM;
            end
            tmtc_pkg::ST_COPY: begin
                cmd.copy_step = 1'b1;
            end
            tmtc_pkg::ST_COPY_LAST: begin
                cmd.walk_start = 1'b1;
                cmd.walk_sel   = tmtc_pkg::WALK_LAST;
            end
            tmtc_pkg::ST_FILL: begin
                cmd.wr_sel    = tmtc_pkg::WR_FILL;
                cmd.walk_step = 1'b1;
            end
            tmtc_pkg::ST_RESP: begin
                cmd.resp_load = status.out_free;
            end
            default: begin
            end
        endcase
    end

`include "text_mode_teletype_console_macros.svh"

    `TMTC_ASSERT_NEXT(a_read_wait, state_reg == tmtc_pkg::ST_RD_WAIT, $past(status.opcode == tmtc_pkg::OP_READ_CHAR), "read wait without a read request")
    `TMTC_ASSERT_NEXT(a_copy_then_fill, state_reg == tmtc_pkg::ST_COPY_LAST, state_reg == tmtc_pkg::ST_FILL, "scroll did not blank the last row")

endmodule

`default_nettype wire

FILE: sv/text_mode_teletype_console.sv
// Character-cell console engine with a rows-by-columns store of 16-bit cells
// (attribute byte above character byte) and a cursor.
// Requests arrive on the s_ channel (valid/ready, s_data holds opcode, character,
// target row and column); each request yields one result on the m_ channel with
// the character read and the cursor after the operation.
// The APB port holds the text attribute register at address 0; writes are
// expected only while the console is idle.
// Single-cell operations go through the EXEC and RESP states before m_valid
// rises, and read_char also through RD_WAIT, set by the registered read port
// of the cell RAM. The next request can be accepted in the same cycle that
// m_valid rises.
// A scroll walks the RAM one cell per cycle, copying each row up by one and then
// blanking the last row; clear_screen and clear_line blank the whole store or
// the target row in the same way.
// After reset the console runs a clearing pass over all ROWS*COLS cells
// that writes blanks with attribute 0x0F; s_ready stays low until it ends.
// The next request may be accepted while a result waits in the output
// register; a stalled m_ready holds that result and the new request finishes
// its work and then waits for the output register to free up.
`default_nettype none

module text_mode_teletype_console (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire tmtc_pkg::in_t                  s_data,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output tmtc_pkg::out_t                      m_data,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [tmtc_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [tmtc_pkg::PDATA_W-1:0]   pwdata,
    output logic      [tmtc_pkg::PDATA_W-1:0]   prdata,
    output logic                                pready
);

    logic [7:0]                       attr_reg;
    logic [tmtc_pkg::REG_IDX_W-1:0]   reg_idx;
    logic                             attr_sel;
    tmtc_pkg::dp_cmd_t                cmd;
    tmtc_pkg::dp_status_t             status;

    assign reg_idx  = paddr[tmtc_pkg::PADDR_W-1:2];
    assign attr_sel = reg_idx == tmtc_pkg::REG_TEXT_ATTR;
    assign pready   = 1'b1;
    assign prdata   = attr_sel ? tmtc_pkg::PDATA_W'(attr_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attr_reg <= tmtc_pkg::RESET_TEXT_ATTR;
        end else if (psel && penable && pwrite && pready && attr_sel) begin
            attr_reg <= pwdata[7:0];
        end
    end

    tmtc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tmtc_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .attr    (attr_reg),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire
